/* rtl/mrb_pkg.sv */
// Package for the modal resonator bank: sizes, request codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrb_pkg;

   localparam int MAX_MODES = 64;
   localparam int MODE_W    = $clog2(MAX_MODES);
   localparam int CNT_W     = $clog2(MAX_MODES + 1);

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_LOAD   = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   localparam logic CSR_ACTIVE_MODES = 1'b0;
   localparam logic CSR_QUIET_LEVEL  = 1'b1;

   typedef struct packed {
      logic              start;   // transaction accepted this cycle
      logic              rd;      // read mode entry
      logic              p1;      // first product stage
      logic              p2;      // state update / second product stage
      logic              p3;      // energy weight product
      logic              p4;      // energy accumulate
      logic              finish;  // load result register
      logic [MODE_W-1:0] mode;
   } mrb_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] mode_cnt;
   } mrb_sts_type;

endpackage
`default_nettype wire

/* rtl/mrb_ctrl.sv */
// Sequencer for the resonator bank: walks the modes for sample and query
// transactions and owns the handshakes. Depends on mrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_type,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire mrb_pkg::mrb_sts_type sts,
   output mrb_pkg::mrb_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_P1   = 3'd2;
   localparam logic [2:0] ST_P2   = 3'd3;
   localparam logic [2:0] ST_P3   = 3'd4;
   localparam logic [2:0] ST_P4   = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [mrb_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic                        query_ff, query_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        accept, last, finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign last      = (mrb_pkg::CNT_W'(mode_ff) + 1'b1) == sts.mode_cnt;
   assign finish    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      query_in     = query_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = '0;
               query_in = (req_type == mrb_pkg::REQ_QUERY);
               if ((req_type == mrb_pkg::REQ_SAMPLE || req_type == mrb_pkg::REQ_QUERY)
                   && sts.mode_cnt != '0) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RD: state_in = ST_P1;
         ST_P1: state_in = ST_P2;
         ST_P2: begin
            if (query_ff) begin
               state_in = ST_P3;
            end else if (last) begin
               state_in = ST_DONE;
            end else begin
               mode_in  = mode_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_P3: state_in = ST_P4;
         ST_P4: begin
            if (last) begin
               state_in = ST_DONE;
            end else begin
               mode_in  = mode_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_DONE: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         query_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         query_ff     <= query_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.start  = accept;
      cmd.rd     = (state_ff == ST_RD);
      cmd.p1     = (state_ff == ST_P1);
      cmd.p2     = (state_ff == ST_P2);
      cmd.p3     = (state_ff == ST_P3);
      cmd.p4     = (state_ff == ST_P4);
      cmd.finish = finish;
      cmd.mode   = mode_ff;
   end

endmodule
`default_nettype wire

/* rtl/mrb_datapath.sv */
// Datapath of the resonator bank: state and coefficient memories, the
// per-mode update and energy arithmetic, accumulators and result register.
// Depends on mrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrb_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mrb_pkg::mrb_cmd_type        cmd,
   output mrb_pkg::mrb_sts_type             sts,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [47:0]                 csr_data,
   input  wire logic [1:0]                  req_type,
   input  wire logic [mrb_pkg::MODE_W-1:0]  req_mode_index,
   input  wire logic signed [15:0]          req_sample_in,
   input  wire logic signed [23:0]          req_coef_plus,
   input  wire logic signed [23:0]          req_coef_minus,
   input  wire logic signed [23:0]          req_coef_gain,
   input  wire logic signed [23:0]          req_level_offset,
   input  wire logic [31:0]                 req_level_weight,
   output logic signed [15:0]               rsp_sample_out,
   output logic [47:0]                      rsp_level_sqr,
   output logic                             rsp_is_quiet
);

   localparam logic [47:0] LEVEL_MAX = '1;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
      if (x > 37'sh0_7FFF_FFFF)        return 32'sh7FFF_FFFF;
      else if (x < -37'sh0_8000_0000)  return 32'sh8000_0000;
      else                             return x[31:0];
   endfunction

   // configuration
   logic [6:0]  active_modes_ff;
   logic [47:0] quiet_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_modes_ff <= '0;
         quiet_level_ff  <= 48'd65536;
      end else if (csr_we) begin
         if (csr_index == mrb_pkg::CSR_ACTIVE_MODES) active_modes_ff <= csr_data[6:0];
         if (csr_index == mrb_pkg::CSR_QUIET_LEVEL)  quiet_level_ff  <= csr_data;
      end
   end

   assign sts.mode_cnt = (active_modes_ff > 7'(mrb_pkg::MAX_MODES))
                         ? mrb_pkg::CNT_W'(mrb_pkg::MAX_MODES)
                         : mrb_pkg::CNT_W'(active_modes_ff);

   // latched transaction
   logic [1:0]          kind_ff;
   logic signed [15:0]  x_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff <= req_type;
         x_ff    <= req_sample_in;
      end
   end

   // memories; entries not yet written read as zero through valid bits
   logic signed [31:0] u_mem  [mrb_pkg::MAX_MODES];
   logic signed [31:0] v_mem  [mrb_pkg::MAX_MODES];
   logic signed [23:0] cp_mem [mrb_pkg::MAX_MODES];
   logic signed [23:0] cm_mem [mrb_pkg::MAX_MODES];
   logic signed [23:0] cg_mem [mrb_pkg::MAX_MODES];
   logic signed [23:0] l0_mem [mrb_pkg::MAX_MODES];
   logic [31:0]        l1_mem [mrb_pkg::MAX_MODES];

   logic [mrb_pkg::MAX_MODES-1:0] uv_valid_ff, uv_valid_in;
   logic [mrb_pkg::MAX_MODES-1:0] cf_valid_ff, cf_valid_in;

   logic signed [31:0] u_rd_ff, v_rd_ff, l1_dummy;
   logic signed [23:0] cp_rd_ff, cm_rd_ff, cg_rd_ff, l0_rd_ff;
   logic [31:0]        l1_rd_ff;
   logic               uv_rv_ff, cf_rv_ff;
   logic signed [31:0] un_sat, vn_sat;
   logic               load_now, wr_state;

   assign load_now = cmd.start && (req_type == mrb_pkg::REQ_LOAD);
   assign wr_state = cmd.p2 && (kind_ff == mrb_pkg::REQ_SAMPLE);
   assign l1_dummy = '0;

   always_ff @(posedge clock) begin
      if (wr_state) begin
         u_mem[cmd.mode] <= un_sat;
         v_mem[cmd.mode] <= vn_sat;
      end
      if (load_now) begin
         cp_mem[req_mode_index] <= req_coef_plus;
         cm_mem[req_mode_index] <= req_coef_minus;
         cg_mem[req_mode_index] <= req_coef_gain;
         l0_mem[req_mode_index] <= req_level_offset;
         l1_mem[req_mode_index] <= req_level_weight;
      end
      if (cmd.rd) begin
         u_rd_ff  <= u_mem[cmd.mode];
         v_rd_ff  <= v_mem[cmd.mode];
         cp_rd_ff <= cp_mem[cmd.mode];
         cm_rd_ff <= cm_mem[cmd.mode];
         cg_rd_ff <= cg_mem[cmd.mode];
         l0_rd_ff <= l0_mem[cmd.mode];
         l1_rd_ff <= l1_mem[cmd.mode];
         uv_rv_ff <= uv_valid_ff[cmd.mode];
         cf_rv_ff <= cf_valid_ff[cmd.mode];
      end
   end

   always_comb begin
      uv_valid_in = uv_valid_ff;
      cf_valid_in = cf_valid_ff;
      if (wr_state) uv_valid_in[cmd.mode] = 1'b1;
      if (cmd.start && req_type == mrb_pkg::REQ_CLEAR) uv_valid_in = '0;
      if (load_now) cf_valid_in[req_mode_index] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_valid_ff <= '0;
         cf_valid_ff <= '0;
      end else begin
         uv_valid_ff <= uv_valid_in;
         cf_valid_ff <= cf_valid_in;
      end
   end

   // gated read data
   logic signed [31:0] u_g, v_g;
   logic signed [23:0] cp_g, cm_g, cg_g, l0_g;
   logic [31:0]        l1_g;

   assign u_g  = uv_rv_ff ? u_rd_ff  : l1_dummy;
   assign v_g  = uv_rv_ff ? v_rd_ff  : l1_dummy;
   assign cp_g = cf_rv_ff ? cp_rd_ff : '0;
   assign cm_g = cf_rv_ff ? cm_rd_ff : '0;
   assign cg_g = cf_rv_ff ? cg_rd_ff : '0;
   assign l0_g = cf_rv_ff ? l0_rd_ff : '0;
   assign l1_g = cf_rv_ff ? l1_rd_ff : '0;

   // first product stage
   logic signed [55:0] pm_ff, pp_ff;
   logic signed [39:0] pg_ff;
   logic signed [51:0] sq_ff;
   logic signed [49:0] uvp_ff;
   logic signed [31:0] u_p_ff, v_p_ff;
   logic signed [23:0] l0_p_ff;
   logic [31:0]        l1_p_ff;
   logic signed [33:0] ssum;
   logic signed [32:0] ur, vr;
   logic signed [25:0] s_q;
   logic signed [24:0] u16, v16;

   assign ssum = 34'(u_g) + 34'(v_g) + 34'sd128;
   assign ur   = 33'(u_g) + 33'sd128;
   assign vr   = 33'(v_g) + 33'sd128;
   assign s_q  = ssum[33:8];
   assign u16  = ur[32:8];
   assign v16  = vr[32:8];

   always_ff @(posedge clock) begin
      if (cmd.p1) begin
         pm_ff   <= 56'(cm_g) * 56'(u_g);
         pp_ff   <= 56'(cp_g) * 56'(v_g);
         pg_ff   <= 40'(cg_g) * 40'(x_ff);
         sq_ff   <= 52'(s_q) * 52'(s_q);
         uvp_ff  <= 50'(u16) * 50'(v16);
         u_p_ff  <= u_g;
         v_p_ff  <= v_g;
         l0_p_ff <= l0_g;
         l1_p_ff <= l1_g;
      end
   end

   // sample update
   logic signed [56:0] pmr, ppr;
   logic signed [40:0] pgr;
   logic signed [36:0] un_w, vn_w;
   logic signed [37:0] acc_ff;

   assign pmr    = 57'(pm_ff) + 57'sd2097152;
   assign ppr    = 57'(pp_ff) + 57'sd2097152;
   assign pgr    = 41'(pg_ff) + 41'sd64;
   assign un_w   = 37'(signed'(pmr[56:22])) - 37'(v_p_ff) + 37'(signed'(pgr[40:7]));
   assign vn_w   = 37'(signed'(ppr[56:22])) + 37'(u_p_ff);
   assign un_sat = sat32(un_w);
   assign vn_sat = sat32(vn_w);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (wr_state) begin
         acc_ff <= acc_ff + 38'(vn_sat);
      end
   end

   // energy stages
   logic signed [50:0] uvr;
   logic [52:0]        sqr;
   logic signed [58:0] crp_ff;
   logic [36:0]        sq16_ff;
   logic signed [59:0] crr;
   logic signed [38:0] b_w;
   logic [37:0]        bu;
   logic [69:0]        tp_ff;
   logic [70:0]        tr;
   logic [54:0]        term_w;
   logic [47:0]        term;
   logic [48:0]        tot_w;
   logic [47:0]        total_ff;

   assign uvr = 51'(uvp_ff) + 51'sd32768;
   assign sqr = 53'(unsigned'(sq_ff)) + 53'd32768;

   always_ff @(posedge clock) begin
      if (cmd.p2) begin
         crp_ff  <= 59'(l0_p_ff) * 59'(signed'(uvr[50:16]));
         sq16_ff <= sqr[52:16];
      end
   end

   assign crr = 60'(crp_ff) + 60'sd2097152;
   assign b_w = 39'(signed'({1'b0, sq16_ff})) + 39'(signed'(crr[59:22]));
   assign bu  = b_w[38] ? '0 : b_w[37:0];

   always_ff @(posedge clock) begin
      if (cmd.p3) begin
         tp_ff <= 70'(l1_p_ff) * 70'(bu);
      end
   end

   assign tr     = 71'(tp_ff) + 71'd32768;
   assign term_w = tr[70:16];
   assign term   = (term_w > 55'(LEVEL_MAX)) ? LEVEL_MAX : term_w[47:0];
   assign tot_w  = 49'(total_ff) + 49'(term);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         total_ff <= '0;
      end else if (cmd.p4) begin
         total_ff <= tot_w[48] ? LEVEL_MAX : tot_w[47:0];
      end
   end

   // result register
   logic signed [38:0] yr;
   logic signed [29:0] y;
   logic signed [15:0] y_sat;

   assign yr    = 39'(acc_ff) + 39'sd256;
   assign y     = yr[38:9];
   assign y_sat = (y > 30'sd32767)  ? 16'sh7FFF :
                  (y < -30'sd32768) ? 16'sh8000 : y[15:0];

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_sample_out <= (kind_ff == mrb_pkg::REQ_SAMPLE) ? y_sat : '0;
         rsp_level_sqr  <= (kind_ff == mrb_pkg::REQ_QUERY) ? total_ff : '0;
         rsp_is_quiet   <= (kind_ff == mrb_pkg::REQ_QUERY) && (total_ff < quiet_level_ff);
      end
   end

endmodule
`default_nettype wire

/* rtl/modal_resonator_bank_core.sv */
// Top level of the modal resonator bank: controller plus datapath.
// Depends on mrb_pkg, mrb_ctrl and mrb_datapath.
//
// Usage:
//  - req_* channel (valid/ready) carries one transaction: sample, load of
//    one mode's coefficients, energy query, or clear of all mode states.
//  - rsp_* channel (valid/ready) returns exactly one result per transaction.
//  - csr_we/csr_index/csr_data write active_modes (0) and quiet_level_sqr (1);
//    write only while the block is idle.
//  - Modes are visited one after another from a single-port memory set.
//    A sample steps through each active mode (read, multiply, update),
//    a query through each active mode (read and three chained multiplies
//    plus accumulate); load, clear, and any transaction with no active
//    modes skip the mode walk. One transaction is in work at a time, so
//    the next is taken only once the last has finished its mode walk.
//  - A result waits in the output register while the receiver stalls; the
//    next transaction is taken meanwhile and is held at its end until the
//    register frees.
//  - Reset (synchronous) zeroes all states and coefficients at once via
//    valid bits, sets active_modes to 0 and quiet_level_sqr to 65536.
`timescale 1ns / 1ps
`default_nettype none
module modal_resonator_bank_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_type,
   input  wire logic [mrb_pkg::MODE_W-1:0]  req_mode_index,
   input  wire logic signed [15:0]          req_sample_in,
   input  wire logic signed [23:0]          req_coef_plus,
   input  wire logic signed [23:0]          req_coef_minus,
   input  wire logic signed [23:0]          req_coef_gain,
   input  wire logic signed [23:0]          req_level_offset,
   input  wire logic [31:0]                 req_level_weight,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [15:0]               rsp_sample_out,
   output logic [47:0]                      rsp_level_sqr,
   output logic                             rsp_is_quiet,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [47:0]                 csr_data
);

   mrb_pkg::mrb_cmd_type cmd;
   mrb_pkg::mrb_sts_type sts;

   mrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mrb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_type         (req_type),
      .req_mode_index   (req_mode_index),
      .req_sample_in    (req_sample_in),
      .req_coef_plus    (req_coef_plus),
      .req_coef_minus   (req_coef_minus),
      .req_coef_gain    (req_coef_gain),
      .req_level_offset (req_level_offset),
      .req_level_weight (req_level_weight),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_level_sqr    (rsp_level_sqr),
      .rsp_is_quiet     (rsp_is_quiet)
   );

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction taken while one is in work");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result raised without a transaction in work");

   a_query_no_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_is_quiet || rsp_level_sqr != '0)) |-> rsp_sample_out == '0)
      else $error("query result carries a sample value");

endmodule
`default_nettype wire

/* test/modal_resonator_bank_core_test.sv */
// Self-checking testbench for modal_resonator_bank_core: a directed table,
// then random traffic, checked against a behavioral model. Needs mrb_pkg.
`timescale 1ns / 1ps
module modal_resonator_bank_core_test;

   typedef struct {
      logic [1:0]         kind;
      logic [5:0]         mode;
      logic signed [15:0] sample;
      logic signed [23:0] cp;
      logic signed [23:0] cm;
      logic signed [23:0] gain;
      logic signed [23:0] l0;
      logic [31:0]        l1;
   } stim_type;

   typedef struct {
      logic signed [15:0] sample;
      logic [47:0]        level;
      logic               quiet;
   } resp_type;

   typedef struct {
      stim_type s;
      logic     known;
      resp_type r;
   } row_type;

   localparam longint LEVEL_MAX = 64'hFFFF_FFFF_FFFF;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic [1:0] req_type = mrb_pkg::REQ_SAMPLE;
   logic [5:0] req_mode_index = 0;
   logic signed [15:0] req_sample_in = 0;
   logic signed [23:0] req_coef_plus = 0, req_coef_minus = 0, req_coef_gain = 0;
   logic signed [23:0] req_level_offset = 0;
   logic [31:0] req_level_weight = 0;
   logic rsp_valid, req_ready;
   logic signed [15:0] rsp_sample_out;
   logic [47:0] rsp_level_sqr;
   logic rsp_is_quiet;
   logic csr_we = 0, csr_index = 0;
   logic [47:0] csr_data = 0;

   modal_resonator_bank_core dut (.*);

   // model state
   longint st_u[mrb_pkg::MAX_MODES], st_v[mrb_pkg::MAX_MODES];
   longint k_cp[mrb_pkg::MAX_MODES], k_cm[mrb_pkg::MAX_MODES];
   longint k_gain[mrb_pkg::MAX_MODES], k_l0[mrb_pkg::MAX_MODES];
   longint k_l1[mrb_pkg::MAX_MODES];
   int     n_active;
   longint quiet_thr;

   resp_type pending[$];
   int       errors = 0;
   bit       idle_off = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint rshift_round(longint x, int n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic resp_type resonate(stim_type s);
      resp_type r;
      longint   acc, un, vn, y, total, term, b, sq, uv, su, u16, v16;
      int       n;
      r = '{0, 0, 0};
      n = n_active > mrb_pkg::MAX_MODES ? mrb_pkg::MAX_MODES : n_active;
      case (s.kind)
         mrb_pkg::REQ_SAMPLE: begin
            acc = 0;
            for (int m = 0; m < n; m++) begin
               un = rshift_round(k_cm[m] * st_u[m], 22) - st_v[m]
                  + rshift_round(k_gain[m] * longint'(s.sample), 7);
               vn = rshift_round(k_cp[m] * st_v[m], 22) + st_u[m];
               st_u[m] = clip32(un);
               st_v[m] = clip32(vn);
               acc += st_v[m];
            end
            y = rshift_round(acc, 9);
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            r.sample = y[15:0];
         end
         mrb_pkg::REQ_LOAD: begin
            k_cp[s.mode] = s.cp;
            k_cm[s.mode] = s.cm;
            k_gain[s.mode] = s.gain;
            k_l0[s.mode] = s.l0;
            k_l1[s.mode] = {32'd0, s.l1};
         end
         mrb_pkg::REQ_QUERY: begin
            total = 0;
            for (int m = 0; m < n; m++) begin
               su = rshift_round(st_u[m] + st_v[m], 8);
               u16 = rshift_round(st_u[m], 8);
               v16 = rshift_round(st_v[m], 8);
               sq = rshift_round(su * su, 16);
               uv = rshift_round(u16 * v16, 16);
               b = sq + rshift_round(k_l0[m] * uv, 22);
               if (b < 0) b = 0;
               term = (k_l1[m] >>> 16) * b + (((k_l1[m] & 64'hFFFF) * b + 64'h8000) >>> 16);
               if (term > LEVEL_MAX) term = LEVEL_MAX;
               total += term;
               if (total > LEVEL_MAX) total = LEVEL_MAX;
            end
            r.level = total[47:0];
            r.quiet = total < quiet_thr;
         end
         default: begin
            for (int m = 0; m < mrb_pkg::MAX_MODES; m++) begin
               st_u[m] = 0;
               st_v[m] = 0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic bit gap();
      return !idle_off && $urandom_range(99) < 6;
   endfunction

   // receiver
   int hold_cnt = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
         rsp_ready <= hold_cnt == 0 && !gap();
         if (rsp_valid && rsp_ready) begin
            if (pending.size() == 0) begin
               $display("%0t: unexpected transaction sample %0d level %0d quiet %0d",
                        $realtime, rsp_sample_out, rsp_level_sqr, rsp_is_quiet);
               errors++;
            end else begin
               resp_type e;
               e = pending.pop_front();
               if (e.sample !== rsp_sample_out) begin
                  $display("%0t: sample_out expected %0d actual %0d", $realtime,
                           e.sample, rsp_sample_out);
                  errors++;
               end
               if (e.level !== rsp_level_sqr) begin
                  $display("%0t: level_sqr expected %0d actual %0d", $realtime,
                           e.level, rsp_level_sqr);
                  errors++;
               end
               if (e.quiet !== rsp_is_quiet) begin
                  $display("%0t: is_quiet expected %0d actual %0d", $realtime,
                           e.quiet, rsp_is_quiet);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send(stim_type s, bit known, resp_type r);
      resp_type p;
      while (gap()) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_type <= s.kind;
      req_mode_index <= s.mode;
      req_sample_in <= s.sample;
      req_coef_plus <= s.cp;
      req_coef_minus <= s.cm;
      req_coef_gain <= s.gain;
      req_level_offset <= s.l0;
      req_level_weight <= s.l1;
      do @(posedge clock); while (!req_ready);
      p = resonate(s);
      pending.push_back(known ? r : p);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (3 * mrb_pkg::MAX_MODES + 10) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, longint value);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= value[47:0];
      @(posedge clock);
      csr_we <= 0;
      if (idx == mrb_pkg::CSR_ACTIVE_MODES) n_active = int'(value & 64'h7F);
      else quiet_thr = value & LEVEL_MAX;
      @(posedge clock);
   endtask

   function automatic stim_type rand_stim(bit tame);
      stim_type s;
      int r;
      r = $urandom_range(99);
      s.kind = r < 60 ? mrb_pkg::REQ_SAMPLE : r < 80 ? mrb_pkg::REQ_LOAD :
               r < 95 ? mrb_pkg::REQ_QUERY : mrb_pkg::REQ_CLEAR;
      s.mode = 6'($urandom);
      s.sample = 16'($urandom);
      s.l1 = $urandom;
      if (tame) begin
         // keep modes decaying so the states stay in range
         s.cp = 24'(24'sd4194304 - $urandom_range(200000));
         s.cm = 24'(24'sd4194304 - $urandom_range(200000));
         s.gain = 24'($urandom_range(131072) - 65536);
         s.l0 = 24'(-$urandom_range(8388608));
      end else begin
         s.cp = 24'($urandom);
         s.cm = 24'($urandom);
         s.gain = 24'($urandom);
         s.l0 = 24'($urandom);
      end
      return s;
   endfunction

   initial begin
      row_type  dir[$];
      resp_type z;
      z = '{0, 0, 0};
      n_active = 0;
      quiet_thr = 65536;
      for (int m = 0; m < mrb_pkg::MAX_MODES; m++) begin
         st_u[m] = 0; st_v[m] = 0; k_cp[m] = 0; k_cm[m] = 0;
         k_gain[m] = 0; k_l0[m] = 0; k_l1[m] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 0;

      // no active modes after reset: everything reads zero, query is quiet
      dir.push_back('{'{mrb_pkg::REQ_SAMPLE, 0, 16'sh7FFF, 0, 0, 0, 0, 0}, 1, z});
      dir.push_back('{'{mrb_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1}});
      dir.push_back('{'{mrb_pkg::REQ_LOAD, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                        24'sh800000, 32'hFFFFFFFF}, 1, z});
      dir.push_back('{'{mrb_pkg::REQ_LOAD, 63, 0, 24'sh800000, 24'sh800000, 24'sh800000,
                        0, 32'h00010000}, 1, z});
      dir.push_back('{'{mrb_pkg::REQ_LOAD, 1, 0, 24'sh3F0000, 24'sh3E0000, 24'sh010000,
                        24'shE00000, 32'h00020000}, 1, z});
      dir.push_back('{'{mrb_pkg::REQ_CLEAR, 5, 16'sh8000, 0, 0, 0, 0, 0}, 1, z});
      foreach (dir[i]) send(dir[i].s, dir[i].known, dir[i].r);
      drain();

      write_csr(mrb_pkg::CSR_ACTIVE_MODES, 64);
      write_csr(mrb_pkg::CSR_QUIET_LEVEL, 0);
      dir.delete();
      dir.push_back('{'{mrb_pkg::REQ_SAMPLE, 0, 16'sh7FFF, 0, 0, 0, 0, 0}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_SAMPLE, 0, 16'sh8000, 0, 0, 0, 0, 0}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_SAMPLE, 0, 16'sh8000, 0, 0, 0, 0, 0}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_SAMPLE, 0, 16'sh7FFF, 0, 0, 0, 0, 0}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0}, 0, z});
      // positive offset drives the energy bracket negative
      dir.push_back('{'{mrb_pkg::REQ_LOAD, 1, 0, 24'sh3F0000, 24'sh3E0000, 24'sh010000,
                        24'sh7FFFFF, 32'h00020000}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0}, 0, z});
      dir.push_back('{'{mrb_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0}});
      foreach (dir[i]) send(dir[i].s, dir[i].known, dir[i].r);
      drain();
      write_csr(mrb_pkg::CSR_ACTIVE_MODES, 127);
      write_csr(mrb_pkg::CSR_QUIET_LEVEL, LEVEL_MAX);
      for (int i = 0; i < 4; i++) send(rand_stim(0), 0, z);
      drain();

      for (int i = 0; i < 900; i++) begin
         if (i % 150 == 0) begin
            drain();
            write_csr(mrb_pkg::CSR_ACTIVE_MODES, (i / 150) % 2 ? $urandom_range(8)
                                                                : $urandom_range(127));
            write_csr(mrb_pkg::CSR_QUIET_LEVEL, {$urandom, $urandom} & LEVEL_MAX);
         end
         if (i == 300) hold_cnt = 400;
         if (i == 500) begin
            drain();
            idle_off = 1;
         end
         if (i == 650) idle_off = 0;
         send(rand_stim($urandom_range(9) != 0), 0, z);
      end
      drain();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
